// ----- rtl/sphs_pkg.sv -----
package sphs_pkg;

    // Fixed-point formats
    localparam int FracBits    = 14;
    localparam int RandBits    = 16;
    localparam int CordicSteps = 28;
    localparam int SqrtSteps   = FracBits + 1;
    localparam int CordicW     = 33;
    localparam int SqrtW       = 30;

    localparam logic signed [CordicW-1:0] CordicStart = 33'sd652032874;
    localparam logic signed [CordicW-1:0] CordicOne   = 33'sd1073741824;

    typedef struct packed {
        logic        [15:0] rand_u;
        logic        [15:0] rand_v;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               was_flipped;
    } t_out_beat;

    // Rotation and square-root state carried down the pipe
    typedef struct packed {
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic signed [CordicW-1:0] ang;
        logic        [SqrtW-1:0]   rem;
        logic        [SqrtW-1:0]   root;
    } t_cordic;

    // Side data that only rides along
    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic        [1:0]  quad;
    } t_side;

    // Arctangent of 2^-i in 2^-32 turns
    function automatic logic signed [CordicW-1:0] atan_turn(input int i);
        logic signed [CordicW-1:0] a;
        unique case (i)
            0:  a = 33'sd536870912;
            1:  a = 33'sd316933406;
            2:  a = 33'sd167458907;
            3:  a = 33'sd85004756;
            4:  a = 33'sd42667331;
            5:  a = 33'sd21354465;
            6:  a = 33'sd10679838;
            7:  a = 33'sd5340245;
            8:  a = 33'sd2670163;
            9:  a = 33'sd1335087;
            10: a = 33'sd667544;
            11: a = 33'sd333772;
            12: a = 33'sd166886;
            13: a = 33'sd83443;
            14: a = 33'sd41722;
            15: a = 33'sd20861;
            16: a = 33'sd10430;
            17: a = 33'sd5215;
            18: a = 33'sd2608;
            19: a = 33'sd1304;
            20: a = 33'sd652;
            21: a = 33'sd326;
            22: a = 33'sd163;
            23: a = 33'sd81;
            24: a = 33'sd41;
            25: a = 33'sd20;
            26: a = 33'sd10;
            27: a = 33'sd5;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/sphere_hemisphere_direction_sampler_core.sv -----
// Channel | Signals                              | Beat
// in      | i_in_valid, o_in_ready, i_in_data    | rand_u, rand_v, normal xyz
// out     | o_out_valid, i_out_ready, o_out_data | dir xyz, was_flipped
// cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data | hemisphere_mode
//
// One beat per cycle while the output is not stalled; 28 rotation stages (the square
// root digits run in the first 15 of them) and 4 scale/dot/flip stages.
// Reset is synchronous, active low, and clears all valid bits and the mode.
// A stall at the output holds the whole pipe; input is taken whenever the
// output register is empty or being drained.
module sphere_hemisphere_direction_sampler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sphs_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sphs_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    localparam int N = sphs_pkg::CordicSteps;

    logic r_mode;
    logic en;

    logic              v   [N+1];
    sphs_pkg::t_cordic st  [N+1];
    sphs_pkg::t_side   sd  [N+1];

    logic signed [15:0] z0;
    logic signed [31:0] zz;

    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // polar cosine, root operand, phase
    assign z0 = $signed({1'b0, i_in_data.rand_v[15:1]}) - 16'sd16384;
    assign zz = z0 * z0;

    assign v[0]       = i_in_valid;
    assign st[0].x    = sphs_pkg::CordicStart;
    assign st[0].y    = '0;
    assign st[0].ang  = $signed({3'b000, i_in_data.rand_u[13:0], 16'h0000});
    assign st[0].rem  = sphs_pkg::SqrtW'(32'sd268435456 - zz);
    assign st[0].root = '0;
    assign sd[0].z    = z0;
    assign sd[0].nx   = i_in_data.normal_x;
    assign sd[0].ny   = i_in_data.normal_y;
    assign sd[0].nz   = i_in_data.normal_z;
    assign sd[0].quad = i_in_data.rand_u[15:14];

    for (genvar g = 0; g < N; g++) begin : g_stage
        sphs_cordic_stage #(.STEP(g)) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(v[g]),
            .i_st   (st[g]),
            .i_side (sd[g]),
            .o_valid(v[g+1]),
            .o_st   (st[g+1]),
            .o_side (sd[g+1])
        );
    end

    sphs_post u_post (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_mode (r_mode),
        .i_valid(v[N]),
        .i_st   (st[N]),
        .i_side (sd[N]),
        .o_valid(o_out_valid),
        .o_beat (o_out_data)
    );

    // full sphere mode never flips
    a_no_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_mode |-> !o_out_data.was_flipped)
        else $error("flip in full sphere mode");

    // z stays inside the unit range
    a_z_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.dir_z >= -16'sd16384) && (o_out_data.dir_z <= 16'sd16384))
        else $error("dir_z out of range");

    // a held result keeps the pipe frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result lost under stall");

endmodule

// ----- rtl/sphs_cordic_stage.sv -----
module sphs_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  sphs_pkg::t_cordic i_st,
    input  sphs_pkg::t_side   i_side,
    output logic              o_valid,
    output sphs_pkg::t_cordic o_st,
    output sphs_pkg::t_side   o_side
);

    localparam int SqSh = (STEP < sphs_pkg::SqrtSteps) ? 2 * (sphs_pkg::SqrtSteps - 1 - STEP) : 0;
    localparam logic [sphs_pkg::SqrtW-1:0] SqBit = sphs_pkg::SqrtW'(1) << SqSh;
    localparam logic signed [sphs_pkg::CordicW-1:0] Atan = sphs_pkg::atan_turn(STEP);

    logic              r_valid;
    sphs_pkg::t_cordic r_st;
    sphs_pkg::t_side   r_side;
    sphs_pkg::t_cordic n_st;
    logic [sphs_pkg::SqrtW-1:0] trial;

    // One rotation step, plus one root digit in the early stages
    always_comb begin
        n_st  = i_st;
        trial = i_st.root + SqBit;
        if (i_st.ang >= 0) begin
            n_st.x   = i_st.x - (i_st.y >>> STEP);
            n_st.y   = i_st.y + (i_st.x >>> STEP);
            n_st.ang = i_st.ang - Atan;
        end else begin
            n_st.x   = i_st.x + (i_st.y >>> STEP);
            n_st.y   = i_st.y - (i_st.x >>> STEP);
            n_st.ang = i_st.ang + Atan;
        end
        if (STEP < sphs_pkg::SqrtSteps) begin
            if (i_st.rem >= trial) begin
                n_st.rem  = i_st.rem - trial;
                n_st.root = (i_st.root >> 1) + SqBit;
            end else begin
                n_st.root = i_st.root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st   <= n_st;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;
    assign o_side  = r_side;

endmodule

// ----- rtl/sphs_post.sv -----
module sphs_post (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_mode,
    input  logic                i_valid,
    input  sphs_pkg::t_cordic   i_st,
    input  sphs_pkg::t_side     i_side,
    output logic                o_valid,
    output sphs_pkg::t_out_beat o_beat
);

    logic [3:0] r_valid;

    // stage 1: clamp, quadrant, scale by radius
    logic signed [sphs_pkg::CordicW-1:0] xc, yc;
    logic signed [31:0] c, s;
    logic signed [48:0] r_pc, r_ps;
    sphs_pkg::t_side    r_side1;

    always_comb begin
        xc = i_st.x;
        yc = i_st.y;
        if (xc > sphs_pkg::CordicOne) xc = sphs_pkg::CordicOne;
        if (xc < -sphs_pkg::CordicOne) xc = -sphs_pkg::CordicOne;
        if (yc > sphs_pkg::CordicOne) yc = sphs_pkg::CordicOne;
        if (yc < -sphs_pkg::CordicOne) yc = -sphs_pkg::CordicOne;
        unique case (i_side.quad)
            2'd0: begin c = 32'(xc);  s = 32'(yc);  end
            2'd1: begin c = 32'(-yc); s = 32'(xc);  end
            2'd2: begin c = 32'(-xc); s = 32'(-yc); end
            default: begin c = 32'(yc); s = 32'(-xc); end
        endcase
    end

    // stage 2: round back to Q1.14
    logic signed [15:0] r_dx, r_dy;
    sphs_pkg::t_side    r_side2;

    // stage 3: dot product terms
    logic signed [31:0] r_tx, r_ty, r_tz;
    logic signed [15:0] r_dx3, r_dy3, r_z3;

    // stage 4: sign test and flip
    logic signed [33:0] dot;
    logic               flip;
    sphs_pkg::t_out_beat r_out;

    assign dot  = 34'(r_tx) + 34'(r_ty) + 34'(r_tz);
    assign flip = i_mode && dot[33];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pc    <= c * $signed({1'b0, i_st.root[15:0]});
            r_ps    <= s * $signed({1'b0, i_st.root[15:0]});
            r_side1 <= i_side;

            r_dx    <= 16'((r_pc + 49'sd536870912) >>> 30);
            r_dy    <= 16'((r_ps + 49'sd536870912) >>> 30);
            r_side2 <= r_side1;

            r_tx    <= r_side2.nx * r_dx;
            r_ty    <= r_side2.ny * r_dy;
            r_tz    <= r_side2.nz * r_side2.z;
            r_dx3   <= r_dx;
            r_dy3   <= r_dy;
            r_z3    <= r_side2.z;

            r_out.dir_x       <= flip ? -r_dx3 : r_dx3;
            r_out.dir_y       <= flip ? -r_dy3 : r_dy3;
            r_out.dir_z       <= flip ? -r_z3 : r_z3;
            r_out.was_flipped <= flip;
        end
    end

    assign o_valid = r_valid[3];
    assign o_beat  = r_out;

endmodule
